// ----- design/c_escape_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// c_escape_decoder_defines.svh
// Assertion macros used by the checker file of the escape decoder.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_DECODER_DEFINES_SVH
`define C_ESCAPE_DECODER_DEFINES_SVH

// Assertion sampled on clk that is switched off while rst_n is low.
`define CED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assertion sampled on clk that also holds while reset is applied.
`define CED_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ced_pkg.sv -----
// ----------------------------------------------------------------------------
// ced_pkg
// Types, character codes and lookup functions of the escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ced_pkg;

  localparam int CHAR_W = 16;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_AFTER_BS   = 2'd1,
    MODE_HEX_FIRST  = 2'd2,
    MODE_HEX_SECOND = 2'd3
  } mode_t;

  localparam char_t CH_BACKSLASH = 16'h005C;
  localparam char_t CH_LOWER_X   = 16'h0078;
  localparam char_t CH_UPPER_X   = 16'h0058;

  // One decoded result beat.
  typedef struct packed {
    logic  char_valid;
    char_t out_char;
    logic  end_of_text;
  } dec_result_t;

  // Lookup of a known escape letter.
  typedef struct packed {
    logic       hit;
    logic [6:0] code;
  } letter_map_t;

  // Hex digit value with a flag for a valid digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic letter_map_t map_letter(input char_t c);
    letter_map_t m;
    m.hit  = 1'b1;
    m.code = 7'd0;
    case (c)
      16'h0030: m.code = 7'd0;
      16'h006E: m.code = 7'd10;
      16'h0072: m.code = 7'd13;
      16'h0074: m.code = 7'd9;
      16'h0061: m.code = 7'd7;
      16'h0062: m.code = 7'd8;
      16'h0076: m.code = 7'd11;
      16'h0066: m.code = 7'd12;
      16'h0065: m.code = 7'd27;
      16'h005C: m.code = 7'd92;
      16'h0022: m.code = 7'd34;
      16'h003F: m.code = 7'd63;
      16'h0027: m.code = 7'd39;
      default:  m.hit  = 1'b0;
    endcase
    return m;
  endfunction

  function automatic hex_digit_t hex_digit(input char_t c);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      d.value = c[3:0];
    end else if ((c >= 16'h0061 && c <= 16'h0066) ||
                 (c >= 16'h0041 && c <= 16'h0046)) begin
      // Letters a-f and A-F share their low three bits: 1..6 maps to 10..15.
      d.value = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- design/c_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// c_escape_decoder
// Streaming decoder for C-style backslash escapes in 16-bit character text.
// ----------------------------------------------------------------------------
// Each input beat carries one character and a flag that marks the last
// character of a text; each input beat gives exactly one result beat, in
// order, with out_char_valid telling whether out_char holds a decoded
// character and out_end_of_text copying the input's flag. The block takes
// one character per clock while its results are taken: the character is
// captured in an input register when the beat is accepted, decoded by a
// small mode machine, and loaded into an output register when that register
// can load. A full pipe still accepts a new beat in any cycle in which the
// result is taken, and out_ready low stalls only as far as the pipe is full.
`default_nettype none

module c_escape_decoder
  import ced_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  // Input channel.
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire char_t  in_char,
  input  wire logic   in_last_of_text,
  // Result channel.
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic        out_char_valid,
  output char_t       out_char,
  output logic        out_end_of_text
);

  // Input register stage.
  logic        s1_valid_r;
  char_t       s1_char_r;
  logic        s1_last_r;

  // Result register stage.
  logic        out_valid_r;
  dec_result_t out_res_r;

  dec_result_t dec_res;
  logic        out_load;
  logic        s1_move;

  // The result register can load when it is empty or its beat leaves now.
  assign out_load = !out_valid_r || out_ready;
  // The captured character is decoded (and the mode advances) when it moves.
  assign s1_move  = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;

  ced_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_move),
    .in_char (s1_char_r),
    .in_last (s1_last_r),
    .result  (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char;
      s1_last_r <= in_last_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= dec_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_valid  = out_res_r.char_valid;
  assign out_char        = out_res_r.out_char;
  assign out_end_of_text = out_res_r.end_of_text;

endmodule

`default_nettype wire

// ----- design/ced_decode.sv -----
// ----------------------------------------------------------------------------
// ced_decode
// Escape mode machine: decodes one character per advance and holds the mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ced_decode
  import ced_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        advance,
  input  wire char_t       in_char,
  input  wire logic        in_last,
  output dec_result_t      result
);

  mode_t mode_r;
  mode_t mode_nxt;
  mode_t mode_step;
  char_t held_r;
  char_t held_nxt;

  letter_map_t letter;
  hex_digit_t  hi_digit;
  hex_digit_t  lo_digit;

  assign letter   = map_letter(in_char);
  assign hi_digit = hex_digit(held_r);
  assign lo_digit = hex_digit(in_char);

  // Next mode.
  always_comb begin
    mode_step = MODE_NORMAL;
    held_nxt  = held_r;
    case (mode_r)
      MODE_NORMAL: begin
        if (in_char == CH_BACKSLASH) begin
          mode_step = MODE_AFTER_BS;
        end
      end
      MODE_AFTER_BS: begin
        if (!letter.hit && (in_char == CH_LOWER_X || in_char == CH_UPPER_X)) begin
          mode_step = MODE_HEX_FIRST;
        end
      end
      MODE_HEX_FIRST: begin
        if (!in_last) begin
          held_nxt  = in_char;
          mode_step = MODE_HEX_SECOND;
        end
      end
      default: begin
        mode_step = MODE_NORMAL;
      end
    endcase
    // No escape spans two texts.
    mode_nxt = in_last ? MODE_NORMAL : mode_step;
  end

  // Result.
  always_comb begin
    result.char_valid  = 1'b0;
    result.out_char    = '0;
    result.end_of_text = in_last;
    case (mode_r)
      MODE_NORMAL: begin
        if (in_char != CH_BACKSLASH) begin
          result.char_valid = 1'b1;
          result.out_char   = in_char;
        end
      end
      MODE_AFTER_BS: begin
        if (letter.hit) begin
          result.char_valid = 1'b1;
          result.out_char   = {9'd0, letter.code};
        end else if (in_char != CH_LOWER_X && in_char != CH_UPPER_X) begin
          result.char_valid = 1'b1;
          result.out_char   = in_char;
        end
      end
      MODE_HEX_FIRST: begin
        if (in_last && in_char != CH_BACKSLASH) begin
          result.char_valid = 1'b1;
          result.out_char   = in_char;
        end
      end
      default: begin
        result.char_valid = 1'b1;
        if (hi_digit.ok && lo_digit.ok) begin
          result.out_char = {8'd0, hi_digit.value, lo_digit.value};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      held_r <= '0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/ced_checker.sv -----
// ----------------------------------------------------------------------------
// ced_checker
// Port-level checks of the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_escape_decoder_defines.svh"

module ced_checker
  import ced_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_ready,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire logic  out_char_valid,
  input wire char_t out_char,
  input wire logic  out_end_of_text
);

  // A stalled result beat stays offered.
  `CED_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")

  // A stalled result beat keeps its payload.
  `CED_ASSERT(a_out_stable,
              out_valid && !out_ready |=> $stable(out_char_valid) && $stable(out_char)
                                          && $stable(out_end_of_text),
              "result payload changed while stalled")

  // A beat without a character carries a zero character.
  `CED_ASSERT(a_zero_char,
              out_valid && !out_char_valid |-> out_char == 16'd0,
              "nonzero char on empty beat")

  // With the result register empty the input side is never blocked.
  `CED_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

  // Reset leaves no result beat on offer.
  `CED_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result offered right after reset")

endmodule

bind c_escape_decoder ced_checker u_ced_checker (.*);

`default_nettype wire
